// File: design/smrq_pkg.sv
// Package for the sorted multiset rank query block.
// Holds the request and response payload types, opcodes, sizes and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
package smrq_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int MAX_RANK     = 8;
   localparam int VALUE_W      = 63;
   localparam int RANK_W       = 4;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_AT_BELOW = 2'd1,
      OP_AT_ABOVE = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [VALUE_W-1:0]  value;
      logic [RANK_W-1:0]   rank;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  result_value;
      logic                store_overflowed;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic srch_rd;
      logic srch_cmp;
      logic shift_rd;
      logic shift_wr;
      logic ins_wr;
      logic res_rd;
      logic res_load;
      logic set_ovf;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       search_done;
      logic       shift_done;
      logic       full;
      logic       rsp_free;
      logic       ovf;
   } stat_type;

endpackage

// File: design/smrq_ctrl.sv
// Controller state machine for the sorted multiset rank query block.
// Sequences search, shift, insert and result steps; depends on smrq_pkg.
`timescale 1ns / 1ps
module smrq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smrq_pkg::stat_type stat,
   output smrq_pkg::cmd_type  cmd
);
   import smrq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DECODE   = 9'b000000010,
      ST_SRCH_RD  = 9'b000000100,
      ST_SRCH_CMP = 9'b000001000,
      ST_SHIFT_RD = 9'b000010000,
      ST_SHIFT_WR = 9'b000100000,
      ST_INS_WR   = 9'b001000000,
      ST_RES_RD   = 9'b010000000,
      ST_RES_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op == OP_UNUSED) begin
               state_in = ST_IDLE;
            end else if (stat.op == OP_INSERT && stat.full) begin
               cmd.set_ovf = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (stat.search_done) begin
               state_in = (stat.op == OP_INSERT) ? ST_SHIFT_RD : ST_RES_RD;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = ST_SRCH_RD;
         end
         ST_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = ST_INS_WR;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RES_RD: begin
            cmd.res_rd = 1'b1;
            state_in   = ST_RES_OUT;
         end
         ST_RES_OUT: begin
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/smrq_dp.sv
// Datapath for the sorted multiset rank query block: the value memory,
// search bounds, shift index, counters and the response register; uses smrq_pkg.
`timescale 1ns / 1ps
module smrq_dp #(
   parameter int CAPACITY = smrq_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  smrq_pkg::req_type  req_data,
   input  smrq_pkg::cmd_type  cmd,
   output smrq_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smrq_pkg::rsp_type  rsp_data
);
   import smrq_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rdata_ff;

   opcode_type         op_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic [CNT_W-1:0]   lo_ff, hi_ff, mid_ff, idx_ff, count_ff;
   logic               ovf_ff;
   logic               found_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid_in;
   logic               go_right;
   logic [CNT_W:0]     rank_ext, lo_ext, count_ext, below_idx, above_idx;
   logic               rank_ok, hit;
   logic [ADDR_W-1:0]  res_addr, raddr, waddr;
   logic               rd_en, wr_en;
   logic [VALUE_W-1:0] wdata;
   logic [CNT_W-1:0]   idx_m1;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in  = mid_sum[CNT_W:1];
   assign idx_m1  = idx_ff - CNT_W'(1);

   assign go_right = (op_ff == OP_AT_ABOVE) ? (rdata_ff < val_ff) : (rdata_ff <= val_ff);

   assign rank_ext  = {{(CNT_W + 1 - RANK_W){1'b0}}, rank_ff};
   assign lo_ext    = {1'b0, lo_ff};
   assign count_ext = {1'b0, count_ff};
   assign below_idx = lo_ext - rank_ext;
   assign above_idx = lo_ext + rank_ext - (CNT_W + 1)'(1);
   assign rank_ok   = (rank_ff != '0) && ({3'b000, rank_ff} <= (RANK_W + 3)'(MAX_RANK));

   always_comb begin
      if (op_ff == OP_AT_BELOW) begin
         hit      = rank_ok && (rank_ext <= lo_ext);
         res_addr = below_idx[ADDR_W-1:0];
      end else begin
         hit      = rank_ok && (above_idx < count_ext);
         res_addr = above_idx[ADDR_W-1:0];
      end
   end

   always_comb begin
      rd_en = 1'b0;
      raddr = mid_in[ADDR_W-1:0];
      if (cmd.srch_rd) begin
         rd_en = 1'b1;
      end else if (cmd.shift_rd) begin
         rd_en = 1'b1;
         raddr = idx_m1[ADDR_W-1:0];
      end else if (cmd.res_rd) begin
         rd_en = hit;
         raddr = res_addr;
      end
   end

   assign wr_en = cmd.shift_wr || cmd.ins_wr;
   assign waddr = cmd.ins_wr ? lo_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign wdata = cmd.ins_wr ? val_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_data.opcode;
         val_ff  <= req_data.value;
         rank_ff <= req_data.rank;
         lo_ff   <= '0;
         hi_ff   <= count_ff;
         idx_ff  <= count_ff;
      end
      if (cmd.srch_rd) begin
         mid_ff <= mid_in;
      end
      if (cmd.srch_cmp) begin
         if (go_right) begin
            lo_ff <= mid_ff + CNT_W'(1);
         end else begin
            hi_ff <= mid_ff;
         end
      end
      if (cmd.shift_wr) begin
         idx_ff <= idx_m1;
      end
      if (cmd.res_rd) begin
         found_ff <= hit;
      end
      if (cmd.res_load) begin
         rsp_data_ff.found            <= found_ff;
         rsp_data_ff.result_value     <= found_ff ? rdata_ff : '0;
         rsp_data_ff.store_overflowed <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.ins_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.op          = op_ff;
   assign stat.search_done = (lo_ff == hi_ff);
   assign stat.shift_done  = (idx_ff == lo_ff);
   assign stat.full        = (count_ff == CNT_W'(CAPACITY));
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign stat.ovf         = ovf_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/sorted_multiset_rank_query.sv
// Sorted multiset rank query: keeps up to CAPACITY values in ascending order in
// one memory and answers k-th at-or-below and k-th at-or-above queries one
// request at a time. Every query, and every insert into a store that is not
// full, first runs a binary search over the stored entries; each step reads
// the single memory read port and then compares. A query then reads its result
// entry; an insert moves each entry above the insert point up one place, a
// read and a write per entry, and then writes the new value. A finished result
// sits in an output register, so a new request is taken while it waits.
// Opcode 3 is taken and dropped. Depends on smrq_pkg, smrq_ctrl and smrq_dp.
`timescale 1ns / 1ps
module sorted_multiset_rank_query #(
   parameter int CAPACITY = smrq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smrq_pkg::rsp_type rsp_data
);
   import smrq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   smrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smrq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset) stat.ovf |=> stat.ovf)
      else $error("overflow flag cleared without reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.store_overflowed || stat.ovf))
      else $error("response reports overflow that never happened");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == OP_INSERT && stat.full)
      |=> ##1 stat.ovf)
      else $error("insert into a full store did not set overflow");

endmodule
